// ===== rtl/ftuc_pkg.sv =====
// Shared constants, result structs and the cumulative-days table for the
// FAT timestamp converter. No dependencies.
`default_nettype none

package ftuc_pkg;

    localparam int NumStages = 9;

    localparam logic [31:0] SecsAt1980  = 32'd315532800;
    localparam logic [16:0] SecsPerDay  = 17'd86400;
    localparam logic [11:0] SecsPerHour = 12'd3600;
    localparam logic [5:0]  SecsPerMin  = 6'd60;
    localparam logic [11:0] DaysTo1980  = 12'd3653;
    localparam logic [11:0] DayBias     = 12'd3652;
    localparam logic [8:0]  DaysPerYear = 9'd365;
    localparam logic [8:0]  LeapDayIdx  = 9'd59;
    localparam logic [7:0]  MaxFatYear  = 8'd127;
    localparam logic [15:0] MaxFatDate  = 16'hFF9F;
    localparam logic [15:0] MaxFatTime  = 16'hBF7D;

    // Rounded-up reciprocals; each is exact over the operand range it sees.
    localparam longint unsigned DayRecipL  = ((64'd1 << 40) + 64'd674) / 64'd675;
    localparam longint unsigned HourRecipL = ((64'd1 << 24) + 64'd224) / 64'd225;
    localparam longint unsigned MinRecipL  = ((64'd1 << 16) + 64'd14) / 64'd15;
    localparam longint unsigned YearRecipL = ((64'd1 << 24) + 64'd364) / 64'd365;

    localparam logic [30:0] DayRecip  = 31'(DayRecipL);
    localparam logic [16:0] HourRecip = 17'(HourRecipL);
    localparam logic [12:0] MinRecip  = 13'(MinRecipL);
    localparam logic [15:0] YearRecip = 16'(YearRecipL);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] sec2;
    } t_clock_fields;

    typedef struct packed {
        logic [7:0] year;
        logic [8:0] day_idx;
        logic [3:0] month;
    } t_calendar;

    function automatic logic [8:0] f_cum_days(input logic [3:0] idx);
        logic [8:0] days;
        unique case (idx)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ftuc_fat_to_unix.sv =====
// Two-stage FAT date/time to Unix seconds datapath with a wrap bit.
// Depends on ftuc_pkg.
`default_nettype none

module ftuc_fat_to_unix (
    input  wire logic        i_clk,
    input  wire logic [1:0]  i_en,
    input  wire logic [15:0] i_fat_date,
    input  wire logic [15:0] i_fat_time,
    output logic      [32:0] o_seconds
);

    logic [3:0]  month_idx;
    logic [6:0]  year;
    logic        leap_fix;
    logic [15:0] n_days;
    logic [16:0] n_tod;
    logic [15:0] r_days;
    logic [16:0] r_tod;
    logic [32:0] r_seconds;

    always_comb begin
        month_idx = 4'(i_fat_date[8:5] - 4'd1);
        year      = i_fat_date[15:9];
        leap_fix  = (year[1:0] == 2'd0) && (month_idx < 4'd2);
        n_days    = 16'(i_fat_date[4:0]) + 16'(ftuc_pkg::f_cum_days(month_idx))
                  + 16'(year[6:2]) + 16'(year) * 16'(ftuc_pkg::DaysPerYear)
                  + 16'(ftuc_pkg::DaysTo1980) - 16'd1 - 16'(leap_fix);
        n_tod     = 17'(i_fat_time[4:0]) * 17'd2
                  + 17'(i_fat_time[10:5]) * 17'(ftuc_pkg::SecsPerMin)
                  + 17'(i_fat_time[15:11]) * 17'(ftuc_pkg::SecsPerHour);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_days <= n_days;
            r_tod  <= n_tod;
        end
        if (i_en[1]) begin
            r_seconds <= 33'(r_days) * 33'(ftuc_pkg::SecsPerDay) + 33'(r_tod);
        end
    end

    assign o_seconds = r_seconds;

endmodule

`default_nettype wire

// ===== rtl/ftuc_day_split.sv =====
// Four-stage front end for Unix to FAT: clamps to 1980, splits seconds into
// whole days since 1980 and seconds of the day. Depends on ftuc_pkg.
`default_nettype none

module ftuc_day_split (
    input  wire logic        i_clk,
    input  wire logic [3:0]  i_en,
    input  wire logic [31:0] i_unix_seconds,
    output logic      [16:0] o_sec_of_day,
    output logic      [15:0] o_days,
    output logic             o_clamp
);

    logic [55:0] day_prod;
    logic [31:0] r1_secs;
    logic        r1_clamp;
    logic [31:0] r2_secs;
    logic [15:0] r2_quot;
    logic        r2_clamp;
    logic [31:0] r3_secs;
    logic [15:0] r3_quot;
    logic [31:0] r3_prod;
    logic        r3_clamp;
    logic [16:0] r4_rem;
    logic [15:0] r4_days;
    logic        r4_clamp;

    // Dividing by 86400 is a shift by 7 and an exact reciprocal of 675.
    assign day_prod = 56'(r1_secs[31:7]) * 56'(ftuc_pkg::DayRecip);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            if (i_unix_seconds < ftuc_pkg::SecsAt1980) begin
                r1_secs  <= ftuc_pkg::SecsAt1980;
                r1_clamp <= 1'b1;
            end else begin
                r1_secs  <= i_unix_seconds;
                r1_clamp <= 1'b0;
            end
        end
        if (i_en[1]) begin
            r2_secs  <= r1_secs;
            r2_quot  <= day_prod[55:40];
            r2_clamp <= r1_clamp;
        end
        if (i_en[2]) begin
            r3_secs  <= r2_secs;
            r3_quot  <= r2_quot;
            r3_prod  <= 32'(32'(r2_quot) * 32'(ftuc_pkg::SecsPerDay));
            r3_clamp <= r2_clamp;
        end
        if (i_en[3]) begin
            r4_rem   <= 17'(r3_secs - r3_prod);
            r4_days  <= r3_quot - 16'(ftuc_pkg::DayBias);
            r4_clamp <= r3_clamp;
        end
    end

    assign o_sec_of_day = r4_rem;
    assign o_days       = r4_days;
    assign o_clamp      = r4_clamp;

endmodule

`default_nettype wire

// ===== rtl/ftuc_clock_fields.sv =====
// Four-stage split of the seconds of a day into hours, minutes and
// seconds/2. Depends on ftuc_pkg.
`default_nettype none

module ftuc_clock_fields (
    input  wire logic                    i_clk,
    input  wire logic [3:0]              i_en,
    input  wire logic [16:0]             i_sec_of_day,
    output ftuc_pkg::t_clock_fields      o_fields
);

    logic [29:0] hour_prod;
    logic [22:0] min_prod;
    logic [5:0]  secs;
    logic [16:0] r5_rem;
    logic [4:0]  r5_hour;
    logic [11:0] r6_rem;
    logic [4:0]  r6_hour;
    logic [11:0] r7_rem;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [4:0]  r8_hour;
    logic [5:0]  r8_min;
    logic [4:0]  r8_sec2;

    assign hour_prod = 30'(i_sec_of_day[16:4]) * 30'(ftuc_pkg::HourRecip);
    assign min_prod  = 23'(r6_rem[11:2]) * 23'(ftuc_pkg::MinRecip);
    assign secs      = 6'(r7_rem - 12'(r7_min) * 12'(ftuc_pkg::SecsPerMin));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r5_rem  <= i_sec_of_day;
            r5_hour <= hour_prod[28:24];
        end
        if (i_en[1]) begin
            r6_rem  <= 12'(r5_rem - 17'(r5_hour) * 17'(ftuc_pkg::SecsPerHour));
            r6_hour <= r5_hour;
        end
        if (i_en[2]) begin
            r7_rem  <= r6_rem;
            r7_hour <= r6_hour;
            r7_min  <= min_prod[21:16];
        end
        if (i_en[3]) begin
            r8_hour <= r7_hour;
            r8_min  <= r7_min;
            r8_sec2 <= secs[5:1];
        end
    end

    assign o_fields.hour   = r8_hour;
    assign o_fields.minute = r8_min;
    assign o_fields.sec2   = r8_sec2;

endmodule

`default_nettype wire

// ===== rtl/ftuc_calendar.sv =====
// Four-stage split of days since 1980 into year, day of year and month,
// with the leap day handled apart. Depends on ftuc_pkg.
`default_nettype none

module ftuc_calendar (
    input  wire logic               i_clk,
    input  wire logic [3:0]         i_en,
    input  wire logic [15:0]        i_days,
    output ftuc_pkg::t_calendar     o_cal
);

    logic [31:0] year_prod;
    logic [7:0]  year_m1;
    logic        leap;
    logic [8:0]  n_day_idx;
    logic [3:0]  n_month;
    logic [15:0] r5_days;
    logic [7:0]  r5_year;
    logic [15:0] r6_days;
    logic [7:0]  r6_year;
    logic [16:0] r6_base0;
    logic [16:0] r6_base1;
    logic [7:0]  r7_year;
    logic [8:0]  r7_doy;
    logic [7:0]  r8_year;
    logic [8:0]  r8_day_idx;
    logic [3:0]  r8_month;

    assign year_prod = 32'(i_days) * 32'(ftuc_pkg::YearRecip);
    assign year_m1   = r5_year - 8'd1;
    assign leap      = (r7_year[1:0] == 2'd0);

    always_comb begin
        n_month = 4'd1;
        if (leap && r7_doy == ftuc_pkg::LeapDayIdx) begin
            n_day_idx = r7_doy;
            n_month   = 4'd2;
        end else begin
            if (!leap || r7_doy <= ftuc_pkg::LeapDayIdx) begin
                n_day_idx = r7_doy;
            end else begin
                n_day_idx = r7_doy - 9'd1;
            end
            for (int j = 1; j < 12; j++) begin
                if (ftuc_pkg::f_cum_days(4'(j)) <= n_day_idx) begin
                    n_month = n_month + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r5_days <= i_days;
            r5_year <= year_prod[31:24];
        end
        if (i_en[1]) begin
            r6_days  <= r5_days;
            r6_year  <= r5_year;
            r6_base0 <= 17'((9'(r5_year) + 9'd3) >> 2)
                      + 17'(r5_year) * 17'(ftuc_pkg::DaysPerYear);
            r6_base1 <= 17'((9'(r5_year) + 9'd2) >> 2)
                      + 17'(year_m1) * 17'(ftuc_pkg::DaysPerYear);
        end
        if (i_en[2]) begin
            if (r6_base0 > 17'(r6_days)) begin
                r7_year <= r6_year - 8'd1;
                r7_doy  <= 9'(17'(r6_days) - r6_base1);
            end else begin
                r7_year <= r6_year;
                r7_doy  <= 9'(17'(r6_days) - r6_base0);
            end
        end
        if (i_en[3]) begin
            r8_year    <= r7_year;
            r8_day_idx <= n_day_idx;
            r8_month   <= n_month;
        end
    end

    assign o_cal.year    = r8_year;
    assign o_cal.day_idx = r8_day_idx;
    assign o_cal.month   = r8_month;

endmodule

`default_nettype wire

// ===== rtl/fat_timestamp_unix_converter_unit.sv =====
// Pipeline of nine stages from an accepted input transaction to its output transaction.
// Throughput: one transaction per cycle when not back-pressured; each stage holds only while
// its successor is full, so bubbles close up under output back-pressure.
// Reset (synchronous, active low) clears the stage valid bits; no other state is reset.
// Depends on ftuc_pkg, ftuc_fat_to_unix, ftuc_day_split, ftuc_clock_fields, ftuc_calendar.
`default_nettype none

module fat_timestamp_unix_converter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] fat_date_in, [31:16] fat_time_in, [63:32] unix_seconds_in
    input  wire logic [63:0] s_axis_tdata,
    // [0] mode
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] unix_seconds_out, [47:32] fat_date_out, [63:48] fat_time_out
    output logic      [63:0] m_axis_tdata,
    // [0] clamped, [1] overflow
    output logic      [1:0]  m_axis_tuser
);

    localparam int Last = ftuc_pkg::NumStages;

    logic [Last:1]           en;
    logic [Last:1]           r_vld;
    logic [Last-1:1]         r_mode;
    logic [Last-1:5]         r_clamp;
    logic [32:0]             r_f2u [3:Last-1];
    logic [32:0]             f2u_secs;
    logic [16:0]             sec_of_day;
    logic [15:0]             days;
    logic                    clamp4;
    ftuc_pkg::t_clock_fields clk_fields;
    ftuc_pkg::t_calendar     cal;
    logic [4:0]              dom;
    logic [31:0]             n_unix;
    logic [15:0]             n_date;
    logic [15:0]             n_time;
    logic                    n_clamp;
    logic                    n_ovf;
    logic [31:0]             r_unix;
    logic [15:0]             r_date;
    logic [15:0]             r_time;
    logic                    r_clamp_o;
    logic                    r_ovf;

    always_comb begin
        en[Last] = !r_vld[Last] || m_axis_tready;
        for (int k = Last - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];

    ftuc_fat_to_unix u_f2u (
        .i_clk      (i_clk),
        .i_en       (en[2:1]),
        .i_fat_date (s_axis_tdata[15:0]),
        .i_fat_time (s_axis_tdata[31:16]),
        .o_seconds  (f2u_secs)
    );

    ftuc_day_split u_split (
        .i_clk          (i_clk),
        .i_en           (en[4:1]),
        .i_unix_seconds (s_axis_tdata[63:32]),
        .o_sec_of_day   (sec_of_day),
        .o_days         (days),
        .o_clamp        (clamp4)
    );

    ftuc_clock_fields u_clock (
        .i_clk        (i_clk),
        .i_en         (en[8:5]),
        .i_sec_of_day (sec_of_day),
        .o_fields     (clk_fields)
    );

    ftuc_calendar u_cal (
        .i_clk  (i_clk),
        .i_en   (en[8:5]),
        .i_days (days),
        .o_cal  (cal)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= Last; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_mode[1] <= s_axis_tuser[0];
        end
        for (int k = 2; k < Last; k++) begin
            if (en[k]) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
        if (en[5]) begin
            r_clamp[5] <= clamp4;
        end
        for (int k = 6; k < Last; k++) begin
            if (en[k]) begin
                r_clamp[k] <= r_clamp[k-1];
            end
        end
        if (en[3]) begin
            r_f2u[3] <= f2u_secs;
        end
        for (int k = 4; k < Last; k++) begin
            if (en[k]) begin
                r_f2u[k] <= r_f2u[k-1];
            end
        end
    end

    always_comb begin
        dom     = 5'(cal.day_idx - ftuc_pkg::f_cum_days(cal.month - 4'd1) + 9'd1);
        n_unix  = '0;
        n_date  = '0;
        n_time  = '0;
        n_clamp = 1'b0;
        n_ovf   = 1'b0;
        if (!r_mode[Last-1]) begin
            n_unix = r_f2u[Last-1][31:0];
            n_ovf  = r_f2u[Last-1][32];
        end else begin
            n_clamp = r_clamp[Last-1];
            if (cal.year > ftuc_pkg::MaxFatYear) begin
                n_date = ftuc_pkg::MaxFatDate;
                n_time = ftuc_pkg::MaxFatTime;
                n_ovf  = 1'b1;
            end else begin
                n_date = {cal.year[6:0], cal.month, dom};
                n_time = {clk_fields.hour, clk_fields.minute, clk_fields.sec2};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[Last]) begin
            r_unix    <= n_unix;
            r_date    <= n_date;
            r_time    <= n_time;
            r_clamp_o <= n_clamp;
            r_ovf     <= n_ovf;
        end
    end

    assign m_axis_tvalid = r_vld[Last];
    assign m_axis_tdata  = {r_time, r_date, r_unix};
    assign m_axis_tuser  = {r_ovf, r_clamp_o};

endmodule

`default_nettype wire

// ===== tb/ftuc_tb_pkg.sv =====
// Timestamp predictor and scoreboard for the FAT timestamp converter testbench.
// Standalone package; tb_top imports it.
package ftuc_tb_pkg;

    typedef enum logic {
        ModeFatToUnix = 1'b0,
        ModeUnixToFat = 1'b1
    } t_mode;

    typedef struct packed {
        logic [31:0] unix_secs;
        logic [15:0] fat_date;
        logic [15:0] fat_time;
        logic        clamped;
        logic        overflow;
    } t_stamp;

    localparam longint unsigned EpochTo1980   = 64'd315532800;
    localparam longint unsigned SecondsPerDay = 64'd86400;
    localparam longint unsigned DaysTo1980    = 64'd3653;
    localparam longint unsigned DayOffset     = 64'd3652;
    localparam longint unsigned LeapDayIndex  = 64'd59;
    localparam longint unsigned LastFatYear   = 64'd127;
    localparam logic [15:0]     SatFatDate    = 16'hFF9F;
    localparam logic [15:0]     SatFatTime    = 16'hBF7D;

    class stamp_scoreboard;
        t_stamp          expected_stamps[$];
        int              mismatches;
        longint unsigned month_start[16];

        function new();
            mismatches  = 0;
            month_start = '{0, 31, 59, 90, 120, 151, 181, 212,
                            243, 273, 304, 334, 0, 0, 0, 0};
        endfunction

        function t_stamp fat_to_unix_stamp(logic [15:0] fdate, logic [15:0] ftime);
            t_stamp          res;
            logic [3:0]      mon_idx;
            longint unsigned yr;
            longint unsigned days;
            longint unsigned secs;
            res     = '0;
            // Month code 0 wraps to index 15, which has no offset.
            mon_idx = fdate[8:5] - 4'd1;
            yr      = 64'(fdate[15:9]);
            days    = 64'(fdate[4:0]) + month_start[mon_idx] + yr / 4 + yr * 365
                      + DaysTo1980 - 1;
            if (yr % 4 == 0 && mon_idx < 4'd2) begin
                days = days - 1;
            end
            secs = 64'(ftime[4:0]) * 2 + 64'(ftime[10:5]) * 60
                   + 64'(ftime[15:11]) * 3600 + SecondsPerDay * days;
            res.unix_secs = secs[31:0];
            res.overflow  = (secs > 64'hFFFF_FFFF);
            return res;
        endfunction

        function t_stamp unix_to_fat_stamp(logic [31:0] secs_in);
            t_stamp          res;
            longint unsigned secs;
            longint unsigned day;
            longint unsigned yr;
            longint unsigned day_in_year;
            longint unsigned mon;
            longint unsigned fdate;
            longint unsigned ftime;
            res  = '0;
            secs = 64'(secs_in);
            if (secs < EpochTo1980) begin
                secs        = EpochTo1980;
                res.clamped = 1'b1;
            end
            ftime = (secs % 60) / 2 + (((secs / 60) % 60) << 5)
                    + (((secs / 3600) % 24) << 11);
            day = secs / SecondsPerDay - DayOffset;
            yr  = day / 365;
            if ((yr + 3) / 4 + 365 * yr > day) begin
                yr = yr - 1;
            end
            day = day - ((yr + 3) / 4 + 365 * yr);
            if (yr > LastFatYear) begin
                res.fat_date = SatFatDate;
                res.fat_time = SatFatTime;
                res.overflow = 1'b1;
                return res;
            end
            if (day == LeapDayIndex && yr % 4 == 0) begin
                day_in_year = day;
                mon         = 2;
            end else begin
                day_in_year = (yr % 4 != 0 || day <= LeapDayIndex) ? day : day - 1;
                mon = 0;
                while (mon < 12 && month_start[mon] <= day_in_year) begin
                    mon = mon + 1;
                end
                if (mon == 0) begin
                    mon = 1;
                end
            end
            fdate = day_in_year - month_start[(mon - 1) & 15] + 1 + (mon << 5) + (yr << 9);
            res.fat_date = fdate[15:0];
            res.fat_time = ftime[15:0];
            return res;
        endfunction

        function void note_input(t_mode mode, logic [63:0] data);
            if (mode == ModeUnixToFat) begin
                expected_stamps.push_back(unix_to_fat_stamp(data[63:32]));
            end else begin
                expected_stamps.push_back(fat_to_unix_stamp(data[15:0], data[31:16]));
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
        endtask

        task check_result(logic [63:0] data, logic [1:0] flags);
            t_stamp want;
            if (expected_stamps.size() == 0) begin
                report("unexpected transaction", data[31:0], '0);
                return;
            end
            want = expected_stamps.pop_front();
            if (data[31:0] !== want.unix_secs) begin
                report("unix_seconds_out", data[31:0], want.unix_secs);
            end
            if (data[47:32] !== want.fat_date) begin
                report("fat_date_out", 32'(data[47:32]), 32'(want.fat_date));
            end
            if (data[63:48] !== want.fat_time) begin
                report("fat_time_out", 32'(data[63:48]), 32'(want.fat_time));
            end
            if (flags[0] !== want.clamped) begin
                report("clamped", 32'(flags[0]), 32'(want.clamped));
            end
            if (flags[1] !== want.overflow) begin
                report("overflow", 32'(flags[1]), 32'(want.overflow));
            end
        endtask
    endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for fat_timestamp_unix_converter_unit: directed and random
// conversions both ways under random back-pressure. Uses ftuc_tb_pkg, ftuc_pkg.
module tb_top;
    import ftuc_tb_pkg::*;

    localparam int  NumItems   = 800;
    localparam int  CycleLimit = 300000;
    localparam int  HoldCycles = 400;
    localparam int  HoldAfter  = 200;
    localparam int  DrainWait  = ftuc_pkg::NumStages + 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    stamp_scoreboard book = new();
    int              results_seen = 0;
    int              gap_free_left = 0;
    int              cycles = 0;

    fat_timestamp_unix_converter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_stamp(t_mode mode, logic [15:0] fdate, logic [15:0] ftime,
                              logic [31:0] secs);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {secs, ftime, fdate};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (gap_free_left > 0) begin
            gap_free_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 3) begin
                gap_free_left = $urandom_range(20, 60);
            end
            gap = idle_length();
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_directed();
        send_stamp(ModeFatToUnix, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_stamp(ModeFatToUnix, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
        send_stamp(ModeFatToUnix, 16'h0021, 16'h0000, 32'h0);
        send_stamp(ModeFatToUnix, 16'h005D, 16'hBF7D, 32'h0);
        send_stamp(ModeFatToUnix, 16'h0061, 16'h0001, 32'h0);
        send_stamp(ModeFatToUnix, 16'h01AF, 16'h1234, 32'h0);
        send_stamp(ModeFatToUnix, 16'h0020, 16'h0000, 32'h0);
        send_stamp(ModeFatToUnix, 16'h0200, 16'hFFE0, 32'h0);
        send_stamp(ModeFatToUnix, 16'hFF9F, 16'hBF7D, 32'h0);
        send_stamp(ModeFatToUnix, 16'hFC47, 16'h3387, 32'h0);
        send_stamp(ModeFatToUnix, 16'hFC47, 16'h3388, 32'h0);
        send_stamp(ModeFatToUnix, 16'h025C, 16'h07FF, 32'h0);
        send_stamp(ModeUnixToFat, 16'hFFFF, 16'hFFFF, 32'd0);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd315532799);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd315532800);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd315532800 + 32'd5140800);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd315532800 + 32'd5184000);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd315532800 + 32'd36720000);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd315532800 + 32'd31622399);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd951782401);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd4233772800);
        send_stamp(ModeUnixToFat, 16'h0000, 16'h0000, 32'd4233772800 - 32'd1);
    endtask

    task automatic send_random();
        t_mode           mode;
        logic [15:0]     fdate;
        logic [15:0]     ftime;
        logic [31:0]     secs;
        longint unsigned yr;
        longint unsigned days;
        longint unsigned wide_secs;
        int              roll;
        mode  = $urandom_range(0, 1) ? ModeUnixToFat : ModeFatToUnix;
        fdate = 16'($urandom);
        ftime = 16'($urandom);
        secs  = $urandom;
        roll  = $urandom_range(0, 99);
        if (mode == ModeFatToUnix) begin
            if (roll < 70) begin
                fdate = {7'($urandom_range(0, 127)), 4'($urandom_range(1, 12)),
                         5'($urandom_range(1, 31))};
                ftime = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                         5'($urandom_range(0, 29))};
            end
        end else if (roll < 50) begin
            secs = $urandom_range(32'hFFFF_FFFF, 32'd315532800);
        end else if (roll < 75) begin
            yr = $urandom_range(0, 125);
            case ($urandom_range(0, 2))
                0:       days = $urandom_range(55, 65);
                1:       days = $urandom_range(0, 2);
                default: days = $urandom_range(362, 366);
            endcase
            days      = days + yr * 365 + (yr + 3) / 4;
            wide_secs = EpochTo1980 + days * SecondsPerDay + $urandom_range(0, 86399);
            secs      = wide_secs[31:0];
        end
        send_stamp(mode, fdate, ftime, secs);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_directed();
        repeat (NumItems) send_random();
        s_axis_tvalid <= 1'b0;
        while (book.expected_stamps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainWait) @(posedge i_clk);
        if (book.mismatches == 0 && book.expected_stamps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : receiver
        bit held;
        int low;
        held = 1'b0;
        repeat (5) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HoldAfter) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 5) begin
                repeat ($urandom_range(40, 100)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            low = idle_length();
            if (low > 0) begin
                m_axis_tready <= 1'b0;
                repeat (low) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                book.note_input(t_mode'(s_axis_tuser[0]), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                book.check_result(m_axis_tdata, m_axis_tuser);
                results_seen++;
            end
        end
    end

    initial begin : watchdog
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ftuc_pkg.sv
rtl/ftuc_fat_to_unix.sv
rtl/ftuc_day_split.sv
rtl/ftuc_clock_fields.sv
rtl/ftuc_calendar.sv
rtl/fat_timestamp_unix_converter_unit.sv
tb/ftuc_tb_pkg.sv
tb/tb_top.sv
